@@ src/spd_pkg.sv @@
package spd_pkg;

    localparam int PAGE_BYTES       = 4096;
    localparam int MAX_SLOTS        = 64;
    localparam int HEADER_BYTES     = 16;
    localparam int SLOT_ENTRY_BYTES = 6;
    localparam int SLOT_AREA_END    = HEADER_BYTES + SLOT_ENTRY_BYTES * MAX_SLOTS;

    localparam int LEN_W  = 13;
    localparam int SLOT_W = 6;
    localparam int HIGH_W = 7;

    localparam logic [2:0] KIND_INSERT  = 3'd0;
    localparam logic [2:0] KIND_GET     = 3'd1;
    localparam logic [2:0] KIND_DELETE  = 3'd2;
    localparam logic [2:0] KIND_COMPACT = 3'd3;
    localparam logic [2:0] KIND_CLEAR   = 3'd4;

    typedef struct packed {
        logic [2:0]        kind;
        logic [LEN_W-1:0]  tuple_length;
        logic [SLOT_W-1:0] slot_index;
    } req_t;

    typedef struct packed {
        logic              status;
        logic [SLOT_W-1:0] slot_out;
        logic [LEN_W-1:0]  tuple_offset;
        logic [LEN_W-1:0]  tuple_len_out;
        logic [LEN_W-1:0]  space_left;
        logic [LEN_W-1:0]  reclaimed_bytes;
    } rsp_t;

    // Command broadcast from the controller to every cell.
    typedef struct packed {
        logic              clear_all;
        logic              write_en;
        logic [SLOT_W-1:0] write_slot;
        logic [LEN_W-1:0]  write_off;
        logic [LEN_W-1:0]  write_len;
        logic              kill_en;
        logic [SLOT_W-1:0] kill_slot;
        logic              compact_step;
        logic [SLOT_W-1:0] compact_slot;
        logic [LEN_W-1:0]  compact_off;
    } cell_cmd_t;

endpackage

@@ src/spd_cell.sv @@
module spd_cell (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [spd_pkg::SLOT_W-1:0]      my_slot,
    input  spd_pkg::cell_cmd_t              cmd,
    input  logic                            free_in,
    input  logic [spd_pkg::SLOT_W-1:0]      free_slot_in,
    output logic                            free_out,
    output logic [spd_pkg::SLOT_W-1:0]      free_slot_out,
    output logic                            live,
    output logic [spd_pkg::LEN_W-1:0]       off,
    output logic [spd_pkg::LEN_W-1:0]       len
);

    logic                       live_reg;
    logic [spd_pkg::LEN_W-1:0]  off_reg;
    logic [spd_pkg::LEN_W-1:0]  len_reg;

    // The first-free search ripples through the chain of cells.
    assign free_out      = free_in | ~live_reg;
    assign free_slot_out = free_in ? free_slot_in : my_slot;
    assign live          = live_reg;
    assign off           = off_reg;
    assign len           = len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg <= 1'b0;
            off_reg  <= '0;
            len_reg  <= '0;
        end
        else if (cmd.clear_all)
        begin
            live_reg <= 1'b0;
            off_reg  <= '0;
            len_reg  <= '0;
        end
        else
        begin
            if (cmd.write_en && cmd.write_slot == my_slot)
            begin
                live_reg <= 1'b1;
                off_reg  <= cmd.write_off;
                len_reg  <= cmd.write_len;
            end
            if (cmd.kill_en && cmd.kill_slot == my_slot)
            begin
                live_reg <= 1'b0;
            end
            if (cmd.compact_step && cmd.compact_slot == my_slot)
            begin
                off_reg <= cmd.compact_off;
            end
        end
    end

endmodule

@@ src/slotted_page_directory_top.sv @@
// Slot directory and free-space pointer of one slotted page.
// Requests arrive on the req channel (req_valid/req_ready) as kind, tuple_length
// and slot_index; one response per request leaves on the rsp channel
// (rsp_valid/rsp_ready) with status, slot, offset, length and byte counts.
// Each slot is a cell in a chain; the first free slot ripples through the chain.
// Insert, get, delete, clear and unknown kinds go from transfer through the execute
// state, which registers the response, to the done state with the response on offer.
// Compact walks the slots from the high mark down, one cell per cycle, and then
// sets the new free end and the response and moves to the done state.
// One request is worked on at a time; req_ready is high only while the block
// is idle, so a new request is accepted only after the previous response is taken.
// A finished response sits in the output register until it is taken;
// while the receiver stalls no new request is accepted.
// Reset empties every slot, sets the high mark to zero and the free end to
// the page size; req_ready is high as soon as reset is released.
module slotted_page_directory_top (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  spd_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output spd_pkg::rsp_t rsp
);

    localparam int NS = spd_pkg::MAX_SLOTS;
    localparam int LW = spd_pkg::LEN_W;
    localparam int SW = spd_pkg::SLOT_W;
    localparam int HW = spd_pkg::HIGH_W;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_EXEC = 4'b0010,
        ST_WALK = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t             state_reg, state_next;
    spd_pkg::req_t      req_reg;
    spd_pkg::rsp_t      rsp_reg, rsp_next;
    logic [HW-1:0]      high_reg, high_next;
    logic [LW-1:0]      end_reg, end_next;
    logic [HW-1:0]      walk_reg, walk_next;
    logic [LW+1:0]      cend_reg, cend_next;
    logic               any_reg, any_next;
    logic [LW-1:0]      oend_reg, oend_next;
    spd_pkg::cell_cmd_t cmd;

    logic [NS:0]        fr_chain;
    logic [SW-1:0]      fs_chain [NS+1];
    logic [NS-1:0]      live_v;
    logic [LW-1:0]      off_v [NS];
    logic [LW-1:0]      len_v [NS];

    assign fr_chain[0] = 1'b0;
    assign fs_chain[0] = '0;

    genvar g;
    generate
        for (g = 0; g < NS; g++)
        begin : g_cell
            spd_cell u_cell (
                .clk           (clk),
                .rst_n         (rst_n),
                .my_slot       (SW'(g)),
                .cmd           (cmd),
                .free_in       (fr_chain[g]),
                .free_slot_in  (fs_chain[g]),
                .free_out      (fr_chain[g+1]),
                .free_slot_out (fs_chain[g+1]),
                .live          (live_v[g]),
                .off           (off_v[g]),
                .len           (len_v[g])
            );
        end
    endgenerate

    function automatic logic [LW-1:0] free_of(input logic [LW-1:0] e);
        logic [LW-1:0] r;
        r = '0;
        if (32'(e) > 32'(spd_pkg::SLOT_AREA_END))
        begin
            r = LW'(32'(e) - 32'(spd_pkg::SLOT_AREA_END));
        end
        return r;
    endfunction

    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = (state_reg == ST_DONE);
    assign rsp       = rsp_reg;

    logic [SW-1:0] wslot;
    logic [LW+1:0] csub;
    logic [LW-1:0] free_now;
    assign wslot    = walk_reg[SW-1:0] - 1'b1;
    assign free_now = free_of(end_reg);
    assign csub     = (cend_reg >= (LW+2)'(len_v[wslot]))
                      ? cend_reg - (LW+2)'(len_v[wslot]) : '0;

    always_comb
    begin
        state_next = state_reg;
        rsp_next   = rsp_reg;
        high_next  = high_reg;
        end_next   = end_reg;
        walk_next  = walk_reg;
        cend_next  = cend_reg;
        any_next   = any_reg;
        oend_next  = oend_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                rsp_next = '0;
                rsp_next.status = 1'b1;
                state_next = ST_DONE;
                case (req_reg.kind)
                    spd_pkg::KIND_INSERT:
                    begin
                        if (req_reg.tuple_length != '0 && 32'(high_reg) < NS
                            && fr_chain[NS] && req_reg.tuple_length <= free_now)
                        begin
                            end_next = end_reg - req_reg.tuple_length;
                            cmd.write_en   = 1'b1;
                            cmd.write_slot = fs_chain[NS];
                            cmd.write_off  = end_next;
                            cmd.write_len  = req_reg.tuple_length;
                            if (HW'(fs_chain[NS]) >= high_reg)
                            begin
                                high_next = HW'(fs_chain[NS]) + 1'b1;
                            end
                            rsp_next.status        = 1'b0;
                            rsp_next.slot_out      = fs_chain[NS];
                            rsp_next.tuple_offset  = end_next;
                            rsp_next.tuple_len_out = req_reg.tuple_length;
                        end
                    end
                    spd_pkg::KIND_GET, spd_pkg::KIND_DELETE:
                    begin
                        rsp_next.slot_out = req_reg.slot_index;
                        if (HW'(req_reg.slot_index) < high_reg
                            && live_v[req_reg.slot_index])
                        begin
                            rsp_next.status = 1'b0;
                            if (req_reg.kind == spd_pkg::KIND_GET)
                            begin
                                rsp_next.tuple_offset  = off_v[req_reg.slot_index];
                                rsp_next.tuple_len_out = len_v[req_reg.slot_index];
                            end
                            else
                            begin
                                cmd.kill_en   = 1'b1;
                                cmd.kill_slot = req_reg.slot_index;
                            end
                        end
                    end
                    spd_pkg::KIND_COMPACT:
                    begin
                        walk_next  = high_reg;
                        cend_next  = (LW+2)'(spd_pkg::PAGE_BYTES);
                        any_next   = 1'b0;
                        oend_next  = end_reg;
                        state_next = ST_WALK;
                    end
                    spd_pkg::KIND_CLEAR:
                    begin
                        cmd.clear_all   = 1'b1;
                        high_next       = '0;
                        end_next        = LW'(spd_pkg::PAGE_BYTES);
                        rsp_next.status = 1'b0;
                    end
                    default:
                    begin
                    end
                endcase
                rsp_next.space_left = free_of(end_next);
            end
            ST_WALK:
            begin
                if (walk_reg != '0)
                begin
                    if (live_v[wslot])
                    begin
                        any_next          = 1'b1;
                        cend_next         = csub;
                        cmd.compact_step  = 1'b1;
                        cmd.compact_slot  = wslot;
                        cmd.compact_off   = LW'(csub);
                    end
                    walk_next = walk_reg - 1'b1;
                end
                else
                begin
                    rsp_next = '0;
                    if (!any_reg)
                    begin
                        cmd.clear_all = 1'b1;
                        high_next     = '0;
                        end_next      = LW'(spd_pkg::PAGE_BYTES);
                    end
                    else
                    begin
                        end_next = LW'(cend_reg);
                    end
                    if (end_next > oend_reg)
                    begin
                        rsp_next.reclaimed_bytes = end_next - oend_reg;
                    end
                    rsp_next.space_left = free_of(end_next);
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (rsp_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            high_reg  <= '0;
            end_reg   <= LW'(spd_pkg::PAGE_BYTES);
            walk_reg  <= '0;
            any_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            high_reg  <= high_next;
            end_reg   <= end_next;
            walk_reg  <= walk_next;
            any_reg   <= any_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            req_reg <= req;
        end
        rsp_reg  <= rsp_next;
        cend_reg <= cend_next;
        oend_reg <= oend_next;
    end

    property p_high_bounded;
        @(posedge clk) disable iff (!rst_n) 32'(high_reg) <= NS;
    endproperty
    a_high_bounded: assert property (p_high_bounded) else $error("high mark overflow");

    property p_walk_ends;
        @(posedge clk) disable iff (!rst_n)
            (state_reg == ST_WALK && walk_reg == '0) |=> state_reg == ST_DONE;
    endproperty
    a_walk_ends: assert property (p_walk_ends) else $error("compact walk did not finish");

    property p_one_action;
        @(posedge clk) disable iff (!rst_n)
            $countones({cmd.write_en, cmd.kill_en, cmd.clear_all}) <= 1;
    endproperty
    a_one_action: assert property (p_one_action) else $error("conflicting cell commands");

    property p_end_floor;
        @(posedge clk) disable iff (!rst_n)
            (state_reg == ST_IDLE) |-> 32'(end_reg) <= spd_pkg::PAGE_BYTES;
    endproperty
    a_end_floor: assert property (p_end_floor) else $error("free end above page");

endmodule

@@ verif/spd_checker.sv @@
`timescale 1ns / 1ps

module spd_checker (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    input  logic          req_ready,
    input  spd_pkg::req_t req,
    input  logic          rsp_valid,
    input  logic          rsp_ready,
    input  spd_pkg::rsp_t rsp,
    output int            fail_count,
    output int            pending_count
);

    localparam int LW = spd_pkg::LEN_W;
    localparam int SW = spd_pkg::SLOT_W;

    logic          page_live [spd_pkg::MAX_SLOTS];
    logic [LW-1:0] page_off [spd_pkg::MAX_SLOTS];
    logic [LW-1:0] page_len [spd_pkg::MAX_SLOTS];
    int            high_mark;
    int            end_ptr;
    spd_pkg::rsp_t expected_rsps [$];

    function automatic void reset_page();
        for (int i = 0; i < spd_pkg::MAX_SLOTS; i++)
        begin
            page_live[i] = 1'b0;
            page_off[i] = '0;
            page_len[i] = '0;
        end
        high_mark = 0;
        end_ptr = spd_pkg::PAGE_BYTES;
    endfunction

    function automatic int free_space();
        return (end_ptr > spd_pkg::SLOT_AREA_END) ? end_ptr - spd_pkg::SLOT_AREA_END : 0;
    endfunction

    function automatic spd_pkg::rsp_t apply_request(spd_pkg::req_t r);
        spd_pkg::rsp_t o;
        int            pick;
        int            old_end;
        int            new_end;
        int            len;
        bit            any;
        o = '0;
        o.status = 1'b1;
        len = r.tuple_length;
        if (r.kind == spd_pkg::KIND_INSERT)
        begin
            pick = -1;
            for (int i = 0; i < spd_pkg::MAX_SLOTS; i++)
                if (pick < 0 && !page_live[i]) pick = i;
            if (len != 0 && high_mark < spd_pkg::MAX_SLOTS && pick >= 0
                && len <= free_space())
            begin
                end_ptr -= len;
                page_off[pick] = LW'(end_ptr);
                page_len[pick] = LW'(len);
                page_live[pick] = 1'b1;
                if (pick >= high_mark) high_mark = pick + 1;
                o.status = 1'b0;
                o.slot_out = SW'(pick);
                o.tuple_offset = LW'(end_ptr);
                o.tuple_len_out = LW'(len);
            end
        end
        else if (r.kind == spd_pkg::KIND_GET || r.kind == spd_pkg::KIND_DELETE)
        begin
            o.slot_out = r.slot_index;
            if (r.slot_index < high_mark && page_live[r.slot_index])
            begin
                o.status = 1'b0;
                if (r.kind == spd_pkg::KIND_GET)
                begin
                    o.tuple_offset = page_off[r.slot_index];
                    o.tuple_len_out = page_len[r.slot_index];
                end
                else
                    page_live[r.slot_index] = 1'b0;
            end
        end
        else if (r.kind == spd_pkg::KIND_COMPACT)
        begin
            old_end = end_ptr;
            new_end = spd_pkg::PAGE_BYTES;
            any = 1'b0;
            for (int s = high_mark - 1; s >= 0; s--)
                if (page_live[s])
                begin
                    any = 1'b1;
                    new_end = (new_end >= page_len[s]) ? new_end - page_len[s] : 0;
                    page_off[s] = LW'(new_end);
                end
            if (!any)
            begin
                reset_page();
                new_end = spd_pkg::PAGE_BYTES;
            end
            else
                end_ptr = new_end;
            o.reclaimed_bytes = (new_end > old_end) ? LW'(new_end - old_end) : '0;
            o.status = 1'b0;
        end
        else if (r.kind == spd_pkg::KIND_CLEAR)
        begin
            reset_page();
            o.status = 1'b0;
        end
        o.space_left = LW'(free_space());
        return o;
    endfunction

    always @(posedge clk)
    begin
        spd_pkg::rsp_t want;
        if (!rst_n)
        begin
            reset_page();
            expected_rsps.delete();
            fail_count = 0;
        end
        else
        begin
            if (req_valid && req_ready)
                expected_rsps.push_back(apply_request(req));
            if (rsp_valid && rsp_ready)
            begin
                if (expected_rsps.size() == 0)
                begin
                    $display("%0t: response with none expected, actual %p", $time, rsp);
                    fail_count++;
                end
                else
                begin
                    want = expected_rsps.pop_front();
                    if (rsp.status !== want.status || rsp.slot_out !== want.slot_out
                        || rsp.tuple_offset !== want.tuple_offset
                        || rsp.tuple_len_out !== want.tuple_len_out
                        || rsp.space_left !== want.space_left
                        || rsp.reclaimed_bytes !== want.reclaimed_bytes)
                    begin
                        $display("%0t: mismatch, expected %p, actual %p", $time, want, rsp);
                        fail_count++;
                    end
                end
            end
        end
        pending_count = expected_rsps.size();
    end

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

    localparam logic [2:0] KIND_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] KIND_UNUSED_LAST  = 3'd7;

    logic          clk;
    logic          rst_n;
    logic          req_valid;
    logic          req_ready;
    spd_pkg::req_t req;
    logic          rsp_valid;
    logic          rsp_ready;
    spd_pkg::rsp_t rsp;
    int            fail_count;
    int            pending_count;
    int            idle_cycles;
    int            sent_count;
    int            resp_count;
    bit            long_stall;

    slotted_page_directory_top dut (
        .clk(clk), .rst_n(rst_n), .req_valid(req_valid), .req_ready(req_ready),
        .req(req), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
    );

    spd_checker checker_i (
        .clk(clk), .rst_n(rst_n), .req_valid(req_valid), .req_ready(req_ready),
        .req(req), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
        .fail_count(fail_count), .pending_count(pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic send(input logic [2:0] kind, input int len, input int slot);
        int gap;
        gap = $urandom_range(0, 11);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        req.kind <= kind;
        req.tuple_length <= spd_pkg::LEN_W'(len);
        req.slot_index <= spd_pkg::SLOT_W'(slot);
        @(posedge clk);
        while (!req_ready) @(posedge clk);
        sent_count++;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        @(negedge clk);
        while (pending_count != 0) @(negedge clk);
    endtask

    function automatic int rand_len();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) return $urandom_range(0, 8191);
        if (pick == 1) return 0;
        if (pick < 4) return $urandom_range(1, 400);
        return $urandom_range(1, 80);
    endfunction

    initial
    begin
        int  hold;
        bit  stall_done;
        rsp_ready = 1'b0;
        stall_done = 1'b0;
        @(negedge clk);
        forever
        begin
            hold = $urandom_range(0, 11);
            if (long_stall && !stall_done)
            begin
                hold = 60;
                stall_done = 1'b1;
            end
            if (hold > 0)
            begin
                rsp_ready <= 1'b0;
                repeat (hold) @(negedge clk);
            end
            rsp_ready <= 1'b1;
            @(posedge clk);
            while (!rsp_valid) @(posedge clk);
            @(negedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            idle_cycles = 0;
            resp_count = 0;
        end
        else
        begin
            if (rsp_valid && rsp_ready) resp_count++;
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles > 2000)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial
    begin
        logic [2:0] k;
        int         r;
        req_valid = 1'b0;
        req = '0;
        rst_n = 1'b0;
        sent_count = 0;
        long_stall = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send(spd_pkg::KIND_GET, 0, 0);
        send(spd_pkg::KIND_DELETE, 0, 63);
        send(spd_pkg::KIND_COMPACT, 0, 0);
        send(spd_pkg::KIND_INSERT, 0, 0);
        send(spd_pkg::KIND_INSERT, 8191, 63);
        send(spd_pkg::KIND_INSERT, 4096, 0);
        send(spd_pkg::KIND_INSERT, 3696, 0);
        send(spd_pkg::KIND_INSERT, 1, 0);
        send(spd_pkg::KIND_GET, 0, 0);
        send(spd_pkg::KIND_CLEAR, 0, 0);
        for (int i = 0; i < 64; i++) send(spd_pkg::KIND_INSERT, 1 + (i % 3), 0);
        send(spd_pkg::KIND_INSERT, 5, 0);
        send(spd_pkg::KIND_DELETE, 0, 5);
        send(spd_pkg::KIND_DELETE, 0, 5);
        send(spd_pkg::KIND_INSERT, 7, 0);
        send(spd_pkg::KIND_DELETE, 0, 63);
        send(spd_pkg::KIND_DELETE, 0, 10);
        send(spd_pkg::KIND_COMPACT, 0, 0);
        send(spd_pkg::KIND_GET, 0, 63);
        send(KIND_UNUSED_FIRST, 8191, 63);
        send(3'(KIND_UNUSED_FIRST + 3'd1), 0, 0);
        send(KIND_UNUSED_LAST, 1, 1);
        send(spd_pkg::KIND_CLEAR, 0, 0);

        wait_drained();
        long_stall = 1'b1;
        for (int i = 0; i < 6; i++) send(spd_pkg::KIND_INSERT, 20, 0);
        wait_drained();

        for (int n = 0; n < 400; n++)
        begin
            r = $urandom_range(0, 99);
            if (r < 40) k = spd_pkg::KIND_INSERT;
            else if (r < 62) k = spd_pkg::KIND_GET;
            else if (r < 84) k = spd_pkg::KIND_DELETE;
            else if (r < 92) k = spd_pkg::KIND_COMPACT;
            else if (r < 96) k = spd_pkg::KIND_CLEAR;
            else k = 3'($urandom_range(KIND_UNUSED_FIRST, KIND_UNUSED_LAST));
            send(k, rand_len(), ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
                 : $urandom_range(0, 15));
            if (n == 200) wait_drained();
        end

        wait_drained();
        repeat (80) @(negedge clk);
        $display("Sent %0d requests of every kind and checked %0d responses,", sent_count,
                 resp_count);
        $display("including a full directory, long output stalls and compaction.");
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
